@@ rtl/core/b3th_pkg.sv @@
// ----------------------------------------------------------------------------
// b3th_pkg: shared types and constants of the tree hasher
// word types, item and result words, flags, job codes, command and status
// ----------------------------------------------------------------------------
package b3th_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0]  cv_t;
  typedef word_t [15:0] msg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [63:0] out_block_index;
  } item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [3:0]  word_index;
    logic        last;
  } result_t;

  localparam logic [1:0] OP_ABSORB  = 2'd0;
  localparam logic [1:0] OP_SQUEEZE = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_KEYED  = 2'd1;
  localparam logic [1:0] MODE_DK_CTX = 2'd2;
  localparam logic [1:0] MODE_DK_MAT = 2'd3;

  localparam logic [2:0] CFG_HASH_MODE = 3'd0;
  localparam logic [2:0] CFG_KEY_0     = 3'd1;
  localparam logic [2:0] CFG_KEY_1     = 3'd2;
  localparam logic [2:0] CFG_KEY_2     = 3'd3;
  localparam logic [2:0] CFG_KEY_3     = 3'd4;

  localparam logic [7:0] FLAG_CHUNK_START = 8'h01;
  localparam logic [7:0] FLAG_CHUNK_END   = 8'h02;
  localparam logic [7:0] FLAG_PARENT      = 8'h04;
  localparam logic [7:0] FLAG_ROOT        = 8'h08;
  localparam logic [7:0] FLAG_KEYED       = 8'h10;
  localparam logic [7:0] FLAG_DK_CONTEXT  = 8'h20;
  localparam logic [7:0] FLAG_DK_MATERIAL = 8'h40;

  localparam int CHUNK_BYTES  = 1024;
  localparam int BLOCK_BYTES  = 64;
  localparam int CHUNK_BLOCKS = CHUNK_BYTES / BLOCK_BYTES;

  localparam cv_t IV = {32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
                        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

  typedef enum logic [2:0] {
    JOB_BLOCK       = 3'd0,
    JOB_CHUNK_END   = 3'd1,
    JOB_PARENT      = 3'd2,
    JOB_ROOT_CHUNK  = 3'd3,
    JOB_ROOT_PARENT = 3'd4
  } job_t;

  typedef struct packed {
    logic       latch_in;
    logic       absorb;
    logic       restart;
    logic       block_done;
    logic       take_cv;
    logic       total_load;
    logic       total_shift;
    logic       pop_read;
    logic       push_new;
    logic       walk_init;
    logic       walk_read;
    logic       start;
    job_t       job;
    logic [3:0] word_idx;
  } cmd_t;

  typedef struct packed {
    logic block_full;
    logic last_block;
    logic merge_more;
    logic stack_empty;
    logic walk_zero;
    logic comp_done;
    logic comp_busy;
  } sts_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one half of the mixing function; first half rotates 16/12, second 8/7
  function automatic quad_t half_g(word_t a, word_t b, word_t c, word_t d,
                                   word_t x, logic first);
    quad_t q;
    q.a = a + b + x;
    q.d = first ? rotr(d ^ q.a, 16) : rotr(d ^ q.a, 8);
    q.c = c + q.d;
    q.b = first ? rotr(b ^ q.c, 12) : rotr(b ^ q.c, 7);
    return q;
  endfunction

  function automatic logic [7:0] mode_flag(logic [1:0] mode);
    logic [7:0] f;
    unique case (mode)
      MODE_KEYED:  f = FLAG_KEYED;
      MODE_DK_CTX: f = FLAG_DK_CONTEXT;
      MODE_DK_MAT: f = FLAG_DK_MATERIAL;
      default:     f = 8'h00;
    endcase
    return f;
  endfunction

  function automatic cv_t select_key(logic [1:0] mode, logic [3:0][63:0] key);
    cv_t k;
    if (mode == MODE_KEYED || mode == MODE_DK_MAT) begin
      k = cv_t'(key);
    end else begin
      k = IV;
    end
    return k;
  endfunction

endpackage

@@ rtl/core/b3th_compress.sv @@
// ----------------------------------------------------------------------------
// b3th_compress: iterative compression unit
// four half mixing steps per round, seven rounds, one step per cycle
// ----------------------------------------------------------------------------
module b3th_compress (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  b3th_pkg::cv_t       cv_in,
  input  b3th_pkg::msg_t      msg,
  input  logic [63:0]         ctr,
  input  logic [6:0]          len,
  input  logic [7:0]          flags,
  output logic                busy,
  output logic                done,
  output b3th_pkg::msg_t      res
);

  localparam int         ROUNDS    = 7;
  localparam logic [4:0] LAST_STEP = 5'(ROUNDS * 4 - 1);

  // state word indices of the four lanes, columns then diagonals
  localparam logic [3:0] GA [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
  localparam logic [3:0] GB [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
  localparam logic [3:0] GC [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
  localparam logic [3:0] GD [8] = '{12, 13, 14, 15, 15, 12, 13, 14};
  localparam logic [3:0] PERM [16] = '{2, 6, 3, 10, 7, 0, 4, 13,
                                       1, 11, 12, 5, 9, 14, 15, 8};

  b3th_pkg::msg_t v, v_next, m, m_next;
  b3th_pkg::cv_t  cvh;
  logic [4:0]     step;
  logic           running;
  logic           fin;

  always_comb begin
    logic [1:0]      phase;
    logic [2:0]      sel;
    b3th_pkg::quad_t q;
    phase  = step[1:0];
    v_next = v;
    for (int g = 0; g < 4; g++) begin
      sel = {phase[1], 2'(g)};
      q = b3th_pkg::half_g(v[GA[sel]], v[GB[sel]], v[GC[sel]], v[GD[sel]],
                           m[{phase[1], 2'(g), phase[0]}], ~phase[0]);
      v_next[GA[sel]] = q.a;
      v_next[GB[sel]] = q.b;
      v_next[GC[sel]] = q.c;
      v_next[GD[sel]] = q.d;
    end
    for (int i = 0; i < 16; i++) begin
      m_next[i] = (phase == 2'd3) ? m[PERM[i]] : m[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 5'd1;
        if (step == LAST_STEP) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v   <= {{24'h0, flags}, {25'h0, len}, ctr[63:32], ctr[31:0],
              b3th_pkg::IV[3], b3th_pkg::IV[2], b3th_pkg::IV[1], b3th_pkg::IV[0],
              cv_in};
      m   <= msg;
      cvh <= cv_in;
    end else if (running) begin
      v <= v_next;
      m <= m_next;
    end
    if (fin) begin
      for (int i = 0; i < 8; i++) begin
        res[i]     <= v[i] ^ v[i + 8];
        res[i + 8] <= v[i + 8] ^ cvh[i];
      end
    end
  end

  assign busy = running | fin;

endmodule

@@ rtl/core/b3th_datapath.sv @@
// ----------------------------------------------------------------------------
// b3th_datapath: chunk state, subtree stack memory and compression unit
// executes one controller command set per cycle
// ----------------------------------------------------------------------------
module b3th_datapath #(
  parameter int STACK_DEPTH = 54
) (
  input  logic                 clk,
  input  logic                 rst,
  input  b3th_pkg::cmd_t       cmd,
  output b3th_pkg::sts_t       sts,
  input  b3th_pkg::item_t      item,
  input  logic [1:0]           hash_mode,
  input  logic [3:0][63:0]     key,
  output logic [31:0]          out_word
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  b3th_pkg::cv_t   cv, tmp, key_w, stack_rd, c_cv;
  logic [511:0]    blk;
  logic [6:0]      fill;
  logic [3:0]      bdone;
  logic [63:0]     chunk_index, total, sq_ctr, c_ctr;
  logic [CW-1:0]   count, walk_n;
  logic [7:0]      byte_q, mflag, sflag, c_flags;
  logic [6:0]      c_len;
  b3th_pkg::msg_t  c_msg, res;
  logic [255:0]    mem [STACK_DEPTH];
  logic [AW-1:0]   rd_addr;
  logic            c_busy, c_done;

  assign key_w = b3th_pkg::select_key(hash_mode, key);
  assign mflag = b3th_pkg::mode_flag(hash_mode);
  assign sflag = (bdone == 4'd0) ? b3th_pkg::FLAG_CHUNK_START : 8'h00;

  always_comb begin
    c_cv    = cv;
    c_msg   = b3th_pkg::msg_t'(blk);
    c_ctr   = chunk_index;
    c_len   = 7'(b3th_pkg::BLOCK_BYTES);
    c_flags = mflag | sflag;
    unique case (cmd.job)
      b3th_pkg::JOB_BLOCK: begin
      end
      b3th_pkg::JOB_CHUNK_END: begin
        c_len   = fill;
        c_flags = mflag | sflag | b3th_pkg::FLAG_CHUNK_END;
      end
      b3th_pkg::JOB_ROOT_CHUNK: begin
        c_len   = fill;
        c_ctr   = sq_ctr;
        c_flags = mflag | sflag | b3th_pkg::FLAG_CHUNK_END | b3th_pkg::FLAG_ROOT;
      end
      b3th_pkg::JOB_PARENT: begin
        c_cv    = key_w;
        c_msg   = {tmp, stack_rd};
        c_ctr   = '0;
        c_flags = mflag | b3th_pkg::FLAG_PARENT;
      end
      b3th_pkg::JOB_ROOT_PARENT: begin
        c_cv    = key_w;
        c_msg   = {tmp, stack_rd};
        c_ctr   = sq_ctr;
        c_flags = mflag | b3th_pkg::FLAG_PARENT | b3th_pkg::FLAG_ROOT;
      end
      default: begin
      end
    endcase
  end

  b3th_compress u_comp (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .cv_in (c_cv),
    .msg   (c_msg),
    .ctr   (c_ctr),
    .len   (c_len),
    .flags (c_flags),
    .busy  (c_busy),
    .done  (c_done),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cv          <= b3th_pkg::IV;
      blk         <= '0;
      fill        <= '0;
      bdone       <= '0;
      chunk_index <= '0;
      count       <= '0;
      walk_n      <= '0;
    end else begin
      if (cmd.restart) begin
        count       <= '0;
        cv          <= key_w;
        blk         <= '0;
        fill        <= '0;
        bdone       <= '0;
        chunk_index <= '0;
      end
      if (cmd.absorb) begin
        blk[fill[5:0] * 8 +: 8] <= byte_q;
        fill                    <= fill + 7'd1;
      end
      if (cmd.block_done) begin
        cv    <= res[7:0];
        bdone <= bdone + 4'd1;
        blk   <= '0;
        fill  <= '0;
      end
      if (cmd.pop_read) begin
        count <= count - CW'(1);
      end
      if (cmd.push_new) begin
        if (count < CW'(STACK_DEPTH)) begin
          count <= count + CW'(1);
        end
        cv          <= key_w;
        blk         <= '0;
        fill        <= '0;
        bdone       <= '0;
        chunk_index <= chunk_index + 64'd1;
      end
      if (cmd.walk_init) begin
        walk_n <= count;
      end
      if (cmd.walk_read) begin
        walk_n <= walk_n - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      byte_q <= item.data_byte;
      sq_ctr <= item.out_block_index;
    end
    if (cmd.take_cv) begin
      tmp <= res[7:0];
    end
    if (cmd.total_load) begin
      total <= chunk_index + 64'd1;
    end else if (cmd.total_shift) begin
      total <= total >> 1;
    end
  end

  // stack memory: one write port, one registered read port
  assign rd_addr = cmd.walk_read ? AW'(walk_n - CW'(1)) : AW'(count - CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.push_new && count < CW'(STACK_DEPTH)) begin
      mem[count[AW-1:0]] <= tmp;
    end
    if (cmd.pop_read || cmd.walk_read) begin
      stack_rd <= mem[rd_addr];
    end
  end

  assign sts.block_full  = fill[6];
  assign sts.last_block  = (bdone == 4'(b3th_pkg::CHUNK_BLOCKS - 1));
  assign sts.merge_more  = !total[0] && (count != '0);
  assign sts.stack_empty = (count == '0);
  assign sts.walk_zero   = (walk_n == '0);
  assign sts.comp_done   = c_done;
  assign sts.comp_busy   = c_busy;

  assign out_word = res[cmd.word_idx];

endmodule

@@ rtl/core/b3th_ctrl.sv @@
// ----------------------------------------------------------------------------
// b3th_ctrl: sequencing state machine
// absorb, block and chunk compression, merges, right edge walk, word output
// ----------------------------------------------------------------------------
module b3th_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic [1:0]      item_op,
  output logic            item_stall,
  output logic            result_valid,
  input  logic            result_stall,
  output b3th_pkg::cmd_t  cmd,
  input  b3th_pkg::sts_t  sts
);

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_ABSORB     = 14'b00000000000010,
    S_BLK_WAIT   = 14'b00000000000100,
    S_END_WAIT   = 14'b00000000001000,
    S_MERGE_CHK  = 14'b00000000010000,
    S_MERGE_GO   = 14'b00000000100000,
    S_MERGE_WAIT = 14'b00000001000000,
    S_PUSH       = 14'b00000010000000,
    S_SQ_GO      = 14'b00000100000000,
    S_WALK_WAIT  = 14'b00001000000000,
    S_WALK_RD    = 14'b00010000000000,
    S_WALK_GO    = 14'b00100000000000,
    S_ROOT_WAIT  = 14'b01000000000000,
    S_OUT        = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  logic [3:0] word_idx, word_idx_next;
  logic       accept;

  assign accept       = item_valid && (state == S_IDLE);
  assign item_stall   = (state != S_IDLE);
  assign result_valid = (state == S_OUT);

  always_comb begin
    cmd           = '0;
    cmd.job       = b3th_pkg::JOB_BLOCK;
    cmd.word_idx  = word_idx;
    cmd.latch_in  = accept;
    state_next    = state;
    word_idx_next = word_idx;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          priority if (item_op == b3th_pkg::OP_ABSORB) begin
            if (sts.block_full && sts.last_block) begin
              cmd.start  = 1'b1;
              cmd.job    = b3th_pkg::JOB_CHUNK_END;
              state_next = S_END_WAIT;
            end else if (sts.block_full) begin
              cmd.start  = 1'b1;
              cmd.job    = b3th_pkg::JOB_BLOCK;
              state_next = S_BLK_WAIT;
            end else begin
              state_next = S_ABSORB;
            end
          end else if (item_op == b3th_pkg::OP_SQUEEZE) begin
            state_next = S_SQ_GO;
          end else if (item_op == b3th_pkg::OP_RESTART) begin
            cmd.restart = 1'b1;
          end else begin
          end
        end
      end
      S_ABSORB: begin
        cmd.absorb = 1'b1;
        state_next = S_IDLE;
      end
      S_BLK_WAIT: begin
        if (sts.comp_done) begin
          cmd.block_done = 1'b1;
          state_next     = S_ABSORB;
        end
      end
      S_END_WAIT: begin
        if (sts.comp_done) begin
          cmd.take_cv    = 1'b1;
          cmd.total_load = 1'b1;
          state_next     = S_MERGE_CHK;
        end
      end
      S_MERGE_CHK: begin
        if (sts.merge_more) begin
          cmd.pop_read = 1'b1;
          state_next   = S_MERGE_GO;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_MERGE_GO: begin
        cmd.start  = 1'b1;
        cmd.job    = b3th_pkg::JOB_PARENT;
        state_next = S_MERGE_WAIT;
      end
      S_MERGE_WAIT: begin
        if (sts.comp_done) begin
          cmd.take_cv     = 1'b1;
          cmd.total_shift = 1'b1;
          state_next      = S_MERGE_CHK;
        end
      end
      S_PUSH: begin
        cmd.push_new = 1'b1;
        state_next   = S_ABSORB;
      end
      S_SQ_GO: begin
        cmd.start = 1'b1;
        if (sts.stack_empty) begin
          cmd.job    = b3th_pkg::JOB_ROOT_CHUNK;
          state_next = S_ROOT_WAIT;
        end else begin
          cmd.job       = b3th_pkg::JOB_CHUNK_END;
          cmd.walk_init = 1'b1;
          state_next    = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        if (sts.comp_done) begin
          cmd.take_cv = 1'b1;
          state_next  = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd.walk_read = 1'b1;
        state_next    = S_WALK_GO;
      end
      S_WALK_GO: begin
        cmd.start = 1'b1;
        if (sts.walk_zero) begin
          cmd.job    = b3th_pkg::JOB_ROOT_PARENT;
          state_next = S_ROOT_WAIT;
        end else begin
          cmd.job    = b3th_pkg::JOB_PARENT;
          state_next = S_WALK_WAIT;
        end
      end
      S_ROOT_WAIT: begin
        if (sts.comp_done) begin
          word_idx_next = '0;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (!result_stall) begin
          word_idx_next = word_idx + 4'd1;
          if (word_idx == 4'd15) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      word_idx <= '0;
    end else begin
      state    <= state_next;
      word_idx <= word_idx_next;
    end
  end

`ifndef SYNTHESIS
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !sts.comp_busy)
    else $error("compression started while unit busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sts.comp_done |-> (state == S_BLK_WAIT || state == S_END_WAIT ||
                       state == S_MERGE_WAIT || state == S_WALK_WAIT ||
                       state == S_ROOT_WAIT))
    else $error("compression finished outside a wait state");

  a_out_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !result_stall && word_idx == 4'd15) |=> state == S_IDLE)
    else $error("no return to idle after last word");
`endif

endmodule

@@ rtl/core/blake3_tree_hasher.sv @@
// ----------------------------------------------------------------------------
// blake3_tree_hasher: incremental tree hasher with extendable root output
// absorb bytes, merge chunk chaining values, squeeze 16-word root blocks
// ----------------------------------------------------------------------------
// absorb: each byte passes the idle and absorb states; a byte that arrives on a
//   full block first waits for the iterative compression unit (28 half mixing
//   steps), one on a full chunk for the chunk end and each parent merge
// squeeze: last chunk, then one parent per stacked entry, the last as root;
//   then 16 words, one per cycle unless stalled; one item is in flight at a time
// reset: synchronous; the subtree stack is not cleared

module blake3_tree_hasher #(
  parameter int STACK_DEPTH = 54
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  b3th_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output b3th_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  // configuration registers, read live by the datapath
  logic [1:0]       hash_mode;
  logic [3:0][63:0] key;

  b3th_pkg::cmd_t   cmd;
  b3th_pkg::sts_t   sts;
  logic [31:0]      dp_word;

  // writes are always taken; indexes beyond the key registers fall away
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode <= b3th_pkg::MODE_PLAIN;
      key       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        b3th_pkg::CFG_HASH_MODE: hash_mode <= cfg_data[1:0];
        b3th_pkg::CFG_KEY_0:     key[0]    <= cfg_data;
        b3th_pkg::CFG_KEY_1:     key[1]    <= cfg_data;
        b3th_pkg::CFG_KEY_2:     key[2]    <= cfg_data;
        b3th_pkg::CFG_KEY_3:     key[3]    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencing: one item at a time, stalls the input while busy
  b3th_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_op      (item.op),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // chunk state, stack memory and compression unit
  b3th_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .hash_mode (hash_mode),
    .key       (key),
    .out_word  (dp_word)
  );

  // result word: held root block, selected by the registered word counter
  assign result.out_word   = dp_word;
  assign result.word_index = cmd.word_idx;
  assign result.last       = (cmd.word_idx == 4'd15);

endmodule
